>>> hw/rtl/alsc_pkg.sv
package alsc_pkg;

    // default number of tokens on a well-formed line
    localparam int TOKENS_PER_LINE_DEF = 4;

    // token counter width, holds up to the saturation value
    localparam int CNT_W = 3;

    // mnemonic table
    localparam int MN_COUNT = 12;
    localparam int MN_CHARS = 4;

    localparam logic [7:0] MN_TEXT [0:MN_COUNT-1][0:MN_CHARS-1] = '{
        '{"N", "U", "L", "L"},
        '{"A", "D", "D", 8'h00},
        '{"S", "U", "B", 8'h00},
        '{"O", "R", 8'h00, 8'h00},
        '{"N", "O", "T", 8'h00},
        '{"A", "N", "D", 8'h00},
        '{"M", "U", "L", 8'h00},
        '{"D", "I", "V", 8'h00},
        '{"J", "E", 8'h00, 8'h00},
        '{"J", "G", 8'h00, 8'h00},
        '{"J", "L", 8'h00, 8'h00},
        '{"J", "M", "P", 8'h00}
    };

    localparam logic [2:0] MN_LEN [0:MN_COUNT-1] = '{
        3'd4, 3'd3, 3'd3, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd2, 3'd2, 3'd2, 3'd3
    };

    // special characters
    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_LBRACK = "[";
    localparam logic [7:0] CHAR_RBRACK = "]";

    // error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_COUNT = 2'd1;
    localparam logic [1:0] ERR_MNEM  = 2'd2;
    localparam logic [1:0] ERR_OPER  = 2'd3;

    // one input transaction
    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_line;
    } t_in_item;

    // one result transaction
    typedef struct packed {
        logic       line_valid;
        logic [1:0] error_kind;
        logic [2:0] tokens_seen;
    } t_out_item;

endpackage

>>> hw/rtl/alsc_line_state.sv
module alsc_line_state #(
    parameter int TOKENS_PER_LINE = alsc_pkg::TOKENS_PER_LINE_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  alsc_pkg::t_in_item  i_item,
    output alsc_pkg::t_out_item o_verdict
);

    localparam logic [alsc_pkg::CNT_W-1:0] TOK_LAST = alsc_pkg::CNT_W'(TOKENS_PER_LINE);
    localparam logic [alsc_pkg::CNT_W-1:0] TOK_SAT  = alsc_pkg::CNT_W'(TOKENS_PER_LINE + 1);

    // number recognizer
    typedef enum logic [8:0] {
        NS_START  = 9'b000000001,
        NS_SIGNED = 9'b000000010,
        NS_ZERO   = 9'b000000100,
        NS_DEC    = 9'b000001000,
        NS_HEX0   = 9'b000010000,
        NS_HEX    = 9'b000100000,
        NS_BIN0   = 9'b001000000,
        NS_BIN    = 9'b010000000,
        NS_BAD    = 9'b100000000
    } t_num;

    // register operand recognizer
    typedef enum logic [3:0] {
        RT_IDLE = 4'b0001,
        RT_R    = 4'b0010,
        RT_OK   = 4'b0100,
        RT_BAD  = 4'b1000
    } t_reg;

    // bracket tracking
    typedef enum logic [2:0] {
        BR_PLAIN  = 3'b001,
        BR_OPEN   = 3'b010,
        BR_CLOSED = 3'b100
    } t_brk;

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_dec(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
    endfunction

    function automatic t_num num_next(input t_num s, input logic [7:0] c);
        t_num r;
        r = NS_BAD;
        unique case (s)
            NS_START: begin
                if (c == "+" || c == "-") r = NS_SIGNED;
                else if (c == "0")        r = NS_ZERO;
                else if (is_dec(c))       r = NS_DEC;
            end
            NS_SIGNED: begin
                if (c == "0")       r = NS_ZERO;
                else if (is_dec(c)) r = NS_DEC;
            end
            NS_ZERO: begin
                if (c == "x" || c == "X")      r = NS_HEX0;
                else if (c == "b" || c == "B") r = NS_BIN0;
                else if (is_dec(c))            r = NS_DEC;
            end
            NS_DEC: begin
                if (is_dec(c)) r = NS_DEC;
            end
            NS_HEX0, NS_HEX: begin
                if (is_hex(c)) r = NS_HEX;
            end
            NS_BIN0, NS_BIN: begin
                if (c == "0" || c == "1") r = NS_BIN;
            end
            NS_BAD: r = NS_BAD;
            default: r = NS_BAD;
        endcase
        return r;
    endfunction

    logic [alsc_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic                          r_inside, n_inside;
    logic [2:0]                    r_pos, n_pos;
    logic [alsc_pkg::MN_COUNT-1:0] r_hits, n_hits;
    t_reg                          r_rt, n_rt;
    t_num                          r_ns, n_ns;
    t_brk                          r_br, n_br;
    logic [1:0]                    r_flags, n_flags;
    logic                          r_ended, n_ended;

    logic                          mn_ok;
    logic                          op_ok;
    logic [alsc_pkg::CNT_W-1:0]    cl_cnt;
    logic [1:0]                    cl_flags;
    logic [2:0]                    b_pos;
    logic [alsc_pkg::MN_COUNT-1:0] b_hits;
    t_reg                          b_rt;
    t_num                          b_ns;
    t_brk                          b_br;
    logic [7:0]                    c;

    assign c = i_item.char_byte;

    // token close: check the finished token and count it
    always_comb begin
        mn_ok = 1'b0;
        for (int i = 0; i < alsc_pkg::MN_COUNT; i++) begin
            if (r_hits[i] && (alsc_pkg::MN_LEN[i] == r_pos)) mn_ok = 1'b1;
        end
        op_ok = (r_rt == RT_OK) ||
                (((r_br == BR_PLAIN) || (r_br == BR_CLOSED)) &&
                 ((r_ns == NS_ZERO) || (r_ns == NS_DEC) || (r_ns == NS_HEX) ||
                  (r_ns == NS_BIN)));
        cl_cnt   = r_cnt;
        cl_flags = r_flags;
        if (r_inside) begin
            if (r_cnt == '0) begin
                if (!mn_ok) cl_flags[0] = 1'b1;
            end else if (r_cnt < TOK_LAST) begin
                if (!op_ok) cl_flags[1] = 1'b1;
            end
            if (r_cnt < TOK_SAT) cl_cnt = r_cnt + 1'b1;
        end
    end

    // verdict from the state after the last close
    always_comb begin
        priority if (cl_cnt != TOK_LAST) o_verdict.error_kind = alsc_pkg::ERR_COUNT;
        else if (cl_flags[0])            o_verdict.error_kind = alsc_pkg::ERR_MNEM;
        else if (cl_flags[1])            o_verdict.error_kind = alsc_pkg::ERR_OPER;
        else                             o_verdict.error_kind = alsc_pkg::ERR_NONE;
        o_verdict.line_valid  = (o_verdict.error_kind == alsc_pkg::ERR_NONE);
        o_verdict.tokens_seen = cl_cnt;
    end

    // next state for one character
    always_comb begin
        // a character outside a token opens a fresh one
        b_pos  = r_inside ? r_pos  : 3'd0;
        b_hits = r_inside ? r_hits : '1;
        b_rt   = r_inside ? r_rt   : RT_IDLE;
        b_ns   = r_inside ? r_ns   : NS_START;
        b_br   = r_inside ? r_br   : BR_PLAIN;

        n_cnt    = r_cnt;
        n_inside = r_inside;
        n_pos    = r_pos;
        n_hits   = r_hits;
        n_rt     = r_rt;
        n_ns     = r_ns;
        n_br     = r_br;
        n_flags  = r_flags;
        n_ended  = r_ended;

        if (i_step) begin
            priority if (i_item.end_of_line) begin
                n_cnt    = '0;
                n_inside = 1'b0;
                n_pos    = 3'd0;
                n_hits   = '1;
                n_rt     = RT_IDLE;
                n_ns     = NS_START;
                n_br     = BR_PLAIN;
                n_flags  = 2'b00;
                n_ended  = 1'b0;
            end else if (r_ended) begin
                n_ended = 1'b1;
            end else if (c == alsc_pkg::CHAR_NUL || c == alsc_pkg::CHAR_SPACE) begin
                n_cnt    = cl_cnt;
                n_flags  = cl_flags;
                n_inside = 1'b0;
                if (c == alsc_pkg::CHAR_NUL) n_ended = 1'b1;
            end else begin
                n_inside = 1'b1;
                n_hits   = b_hits;
                n_rt     = b_rt;
                n_ns     = b_ns;
                n_br     = b_br;
                if (r_cnt == '0) begin
                    // narrow down the mnemonic candidates
                    for (int i = 0; i < alsc_pkg::MN_COUNT; i++) begin
                        if ((b_pos >= alsc_pkg::MN_LEN[i]) ||
                            (alsc_pkg::MN_TEXT[i][b_pos[1:0]] != c)) begin
                            n_hits[i] = 1'b0;
                        end
                    end
                end else begin
                    // register operand
                    unique case (b_rt)
                        RT_IDLE: n_rt = (c == "R") ? RT_R : RT_BAD;
                        RT_R:    n_rt = ((c >= "1") && (c <= "4")) ? RT_OK : RT_BAD;
                        RT_OK:   n_rt = RT_BAD;
                        RT_BAD:  n_rt = RT_BAD;
                        default: n_rt = RT_BAD;
                    endcase
                    // number, plain or in brackets
                    priority if ((b_pos == 3'd0) && (c == alsc_pkg::CHAR_LBRACK)) begin
                        n_br = BR_OPEN;
                    end else if (b_br == BR_PLAIN) begin
                        n_ns = num_next(b_ns, c);
                    end else if (b_br == BR_OPEN) begin
                        if (c == alsc_pkg::CHAR_RBRACK) n_br = BR_CLOSED;
                        else                            n_ns = num_next(b_ns, c);
                    end else begin
                        // text after a closing bracket spoils the number
                        n_ns = NS_BAD;
                        n_br = (c == alsc_pkg::CHAR_RBRACK) ? BR_CLOSED : BR_OPEN;
                    end
                end
                n_pos = (b_pos < 3'd7) ? b_pos + 3'd1 : b_pos;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_inside <= 1'b0;
            r_pos    <= 3'd0;
            r_hits   <= '1;
            r_rt     <= RT_IDLE;
            r_ns     <= NS_START;
            r_br     <= BR_PLAIN;
            r_flags  <= 2'b00;
            r_ended  <= 1'b0;
        end else begin
            r_cnt    <= n_cnt;
            r_inside <= n_inside;
            r_pos    <= n_pos;
            r_hits   <= n_hits;
            r_rt     <= n_rt;
            r_ns     <= n_ns;
            r_br     <= n_br;
            r_flags  <= n_flags;
            r_ended  <= n_ended;
        end
    end

endmodule

>>> hw/rtl/assembly_line_syntax_checker_top.sv
// channel   direction  handshake           payload
// input     in         i_valid / o_stall   i_data  (char_byte, end_of_line)
// result    out        o_valid / i_stall   o_data  (line_valid, error_kind, tokens_seen)
//
// one byte per cycle while o_stall is low; a transaction goes through the input
// register, then the per-character state update; an end-of-line verdict is held in
// the result register that drives o_data while later bytes keep flowing
// o_stall rises only when an end-of-line transaction meets a full, stalled result
// register; synchronous active-low reset clears the line state to an empty line
module assembly_line_syntax_checker_top #(
    parameter int TOKENS_PER_LINE = alsc_pkg::TOKENS_PER_LINE_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  alsc_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output alsc_pkg::t_out_item o_data
);

    logic                r_in_valid;
    alsc_pkg::t_in_item  r_in;
    logic                r_out_valid;
    alsc_pkg::t_out_item r_out;
    logic                step;
    alsc_pkg::t_out_item verdict;

    // hold the input register only when a verdict has nowhere to go
    assign o_stall = r_in_valid && r_in.end_of_line && r_out_valid && i_stall;
    assign step    = r_in_valid && !o_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in <= i_data;
        end
    end

    alsc_line_state #(
        .TOKENS_PER_LINE(TOKENS_PER_LINE)
    ) u_line_state (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_item    (r_in),
        .o_verdict (verdict)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in.end_of_line) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in.end_of_line) begin
            r_out <= verdict;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

>>> hw/rtl/alsc_checker.sv
module alsc_checker #(
    parameter int TOKENS_PER_LINE = alsc_pkg::TOKENS_PER_LINE_DEF
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input alsc_pkg::t_in_item  i_data,
    input logic                o_valid,
    input logic                i_stall,
    input alsc_pkg::t_out_item o_data
);

    localparam logic [2:0] TOK_LAST = 3'(TOKENS_PER_LINE);
    localparam logic [2:0] TOK_SAT  = 3'(TOKENS_PER_LINE + 1);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result changed under stall");

    // input is held back only behind a blocked result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a blocked result");

    // valid flag agrees with the error code
    a_valid_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.line_valid == (o_data.error_kind == alsc_pkg::ERR_NONE))
        else $error("line_valid disagrees with error_kind");

    // a clean line has exactly the expected token count
    a_clean_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.line_valid |-> o_data.tokens_seen == TOK_LAST)
        else $error("valid line with wrong token count");

    // token count never passes its saturation value
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.tokens_seen <= TOK_SAT)
        else $error("token count out of range");

endmodule

bind assembly_line_syntax_checker_top alsc_checker #(
    .TOKENS_PER_LINE(TOKENS_PER_LINE)
) u_alsc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);
